[rtl/tcw_pkg.sv]
// shared types, constants and sizes of the text console writer
package tcw_pkg;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELL_COUNT   = COLUMNS * ROWS;
    localparam int MOVE_COUNT   = CELL_COUNT - COLUMNS;
    localparam int CURSOR_RESET = COLUMNS + 27;
    localparam int ADDR_W       = $clog2(CELL_COUNT);
    localparam int CURSOR_W     = $clog2(CELL_COUNT + 16);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int SUM_W        = $clog2(COLUMNS + 16);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int TAB_W    = 4;
    localparam int INDEX_W  = 11;
    localparam int OUTCUR_W = 11;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [7:0] ATTR_RESET = 8'h07;
    localparam logic [3:0] TAB_RESET  = 4'd4;

    localparam logic       OP_PRINT = 1'b0;
    localparam logic       OP_READ  = 1'b1;

    localparam logic       REG_ATTR = 1'b0;
    localparam logic       REG_TAB  = 1'b1;

    localparam logic [7:0] CH_NUL     = 8'd0;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;

    typedef struct packed {
        logic               opcode;
        logic [CHAR_W-1:0]  character;
        logic [INDEX_W-1:0] cell_index;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]   cell_char;
        logic [ATTR_W-1:0]   cell_attr;
        logic [OUTCUR_W-1:0] cursor_out;
        logic                scrolled;
    } out_item_t;

    typedef enum logic [2:0] {
        CMD_READ,
        CMD_WRITE,
        CMD_NEWLINE,
        CMD_TAB,
        CMD_RETURN,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [CHAR_W-1:0]  character;
        logic [INDEX_W-1:0] cell_index;
    } cmd_t;

endpackage

[rtl/tcw_front.sv]
// front end: accepts requests, classifies them and registers the command
module tcw_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  tcw_pkg::in_item_t s_data,
    input  logic             clearing,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output tcw_pkg::cmd_t    cmd_data
);

    logic          valid_reg;
    tcw_pkg::cmd_t cmd_reg;
    tcw_pkg::cmd_t cmd_next;

    always_comb begin
        cmd_next.character  = s_data.character;
        cmd_next.cell_index = s_data.cell_index;
        priority if (s_data.opcode == tcw_pkg::OP_READ) begin
            cmd_next.kind = tcw_pkg::CMD_READ;
        end else if (s_data.character == tcw_pkg::CH_NEWLINE) begin
            cmd_next.kind = tcw_pkg::CMD_NEWLINE;
        end else if (s_data.character == tcw_pkg::CH_TAB) begin
            cmd_next.kind = tcw_pkg::CMD_TAB;
        end else if (s_data.character == tcw_pkg::CH_RETURN) begin
            cmd_next.kind = tcw_pkg::CMD_RETURN;
        end else if (s_data.character == tcw_pkg::CH_NUL) begin
            cmd_next.kind = tcw_pkg::CMD_NOP;
        end else begin
            cmd_next.kind = tcw_pkg::CMD_WRITE;
        end
    end

    assign s_ready   = !clearing && (!valid_reg || cmd_ready);
    assign cmd_valid = valid_reg;
    assign cmd_data  = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                valid_reg <= 1'b1;
                cmd_reg   <= cmd_next;
            end else if (cmd_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/tcw_queue.sv]
// short command queue between the front end and the execution engine
module tcw_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  tcw_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output tcw_pkg::cmd_t pop_data
);

    tcw_pkg::cmd_t                entry_reg [tcw_pkg::QUEUE_DEPTH];
    logic [tcw_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [tcw_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [tcw_pkg::QCNT_W-1:0]   count_reg;
    logic                         do_push;
    logic                         do_pop;

    assign push_ready = (count_reg != tcw_pkg::QCNT_W'(tcw_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [tcw_pkg::QPTR_W-1:0] bump(input logic [tcw_pkg::QPTR_W-1:0] p);
        if (p == tcw_pkg::QPTR_W'(tcw_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/tcw_back.sv]
// execution engine: screen store, cursor, scroll sweep and result register
module tcw_back (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cmd_valid,
    output logic                      cmd_ready,
    input  tcw_pkg::cmd_t             cmd_data,
    input  logic [tcw_pkg::ATTR_W-1:0] text_attribute,
    input  logic [tcw_pkg::TAB_W-1:0]  tab_advance,
    output logic                      clearing,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tcw_pkg::out_item_t        m_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_ZERO,
        ST_EXEC,
        ST_DONE
    } state_t;

    localparam int AW = tcw_pkg::ADDR_W;
    localparam int CW = tcw_pkg::CURSOR_W;
    localparam int LW = tcw_pkg::COL_W;
    localparam int SW = tcw_pkg::SUM_W;

    state_t              state_reg;
    logic [AW-1:0]       cnt_reg;
    logic [CW-1:0]       cursor_reg;
    logic [LW-1:0]       col_reg;
    tcw_pkg::cmd_t       cmd_reg;
    logic                in_range_reg;
    logic                scrolled_reg;
    logic [15:0]         rdata_reg;
    logic                m_valid_reg;
    tcw_pkg::out_item_t  m_data_reg;

    logic [15:0]         mem [tcw_pkg::CELL_COUNT];

    logic                we;
    logic [AW-1:0]       waddr;
    logic [15:0]         wdata;
    logic                re;
    logic [AW-1:0]       raddr;
    logic                idx_in_range;
    logic [CW-1:0]       cursor_back;
    logic [SW-1:0]       tab_sum;
    logic [LW-1:0]       col_tab;
    logic [LW-1:0]       col_inc;

    assign idx_in_range = (32'(cmd_data.cell_index) < tcw_pkg::CELL_COUNT);
    assign cursor_back  = cursor_reg - CW'(tcw_pkg::COLUMNS);
    assign tab_sum      = SW'(col_reg) + SW'(tab_advance);
    assign col_inc      = (col_reg == LW'(tcw_pkg::COLUMNS - 1)) ? '0 : col_reg + 1'b1;

    always_comb begin
        priority if (32'(tab_sum) >= 2 * tcw_pkg::COLUMNS) begin
            col_tab = LW'(tab_sum - SW'(2 * tcw_pkg::COLUMNS));
        end else if (32'(tab_sum) >= tcw_pkg::COLUMNS) begin
            col_tab = LW'(tab_sum - SW'(tcw_pkg::COLUMNS));
        end else begin
            col_tab = LW'(tab_sum);
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign clearing  = (state_reg == ST_CLEAR);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_comb begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = '0;
        re    = 1'b0;
        raddr = cnt_reg + AW'(tcw_pkg::COLUMNS);
        unique case (state_reg)
            ST_CLEAR: begin
                we = 1'b1;
            end
            ST_IDLE: begin
                re    = cmd_valid && (cmd_data.kind == tcw_pkg::CMD_READ) && idx_in_range;
                raddr = AW'(cmd_data.cell_index);
            end
            ST_SCROLL: begin
                re    = (32'(cnt_reg) < tcw_pkg::MOVE_COUNT);
                we    = (cnt_reg != '0);
                waddr = cnt_reg - 1'b1;
                wdata = rdata_reg;
            end
            ST_ZERO: begin
                we = 1'b1;
            end
            ST_EXEC: begin
                we    = (cmd_reg.kind == tcw_pkg::CMD_WRITE);
                waddr = AW'(cursor_reg);
                wdata = {text_attribute, cmd_reg.character};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            cursor_reg  <= CW'(tcw_pkg::CURSOR_RESET);
            col_reg     <= LW'(tcw_pkg::CURSOR_RESET % tcw_pkg::COLUMNS);
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (32'(cnt_reg) == tcw_pkg::CELL_COUNT - 1) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (cmd_valid) begin
                        cmd_reg      <= cmd_data;
                        in_range_reg <= idx_in_range;
                        if (cmd_data.kind == tcw_pkg::CMD_READ) begin
                            scrolled_reg <= 1'b0;
                            state_reg    <= ST_DONE;
                        end else if (32'(cursor_reg) >= tcw_pkg::CELL_COUNT) begin
                            scrolled_reg <= 1'b1;
                            cnt_reg      <= '0;
                            state_reg    <= ST_SCROLL;
                            if (32'(cursor_back) >= tcw_pkg::CELL_COUNT) begin
                                cursor_reg <= CW'(tcw_pkg::MOVE_COUNT);
                                col_reg    <= '0;
                            end else begin
                                cursor_reg <= cursor_back;
                            end
                        end else begin
                            scrolled_reg <= 1'b0;
                            state_reg    <= ST_EXEC;
                        end
                    end
                end
                ST_SCROLL: begin
                    if (32'(cnt_reg) == tcw_pkg::MOVE_COUNT) begin
                        state_reg <= ST_ZERO;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ZERO: begin
                    if (32'(cnt_reg) == tcw_pkg::CELL_COUNT - 1) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_EXEC;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_EXEC: begin
                    unique case (cmd_reg.kind)
                        tcw_pkg::CMD_WRITE, tcw_pkg::CMD_RETURN: begin
                            cursor_reg <= cursor_reg + 1'b1;
                            col_reg    <= col_inc;
                        end
                        tcw_pkg::CMD_NEWLINE: begin
                            cursor_reg <= cursor_reg + CW'(tcw_pkg::COLUMNS) - CW'(col_reg);
                            col_reg    <= '0;
                        end
                        tcw_pkg::CMD_TAB: begin
                            cursor_reg <= cursor_reg + CW'(tab_advance);
                            col_reg    <= col_tab;
                        end
                        default: begin
                        end
                    endcase
                    state_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        if ((cmd_reg.kind == tcw_pkg::CMD_READ) && in_range_reg) begin
                            m_data_reg.cell_char <= rdata_reg[7:0];
                            m_data_reg.cell_attr <= rdata_reg[15:8];
                        end else begin
                            m_data_reg.cell_char <= '0;
                            m_data_reg.cell_attr <= '0;
                        end
                        m_data_reg.cursor_out <= tcw_pkg::OUTCUR_W'(cursor_reg);
                        m_data_reg.scrolled   <= scrolled_reg;
                        state_reg             <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/text_console_writer.sv]
// top level of the text console writer: register port, front end, queue and engine
//
// A print or read request passes from acceptance through the front-end register, the
// queue, the execute state and the result register; a read skips the execute state.
// A print that finds the cursor past the last cell first scrolls the screen, which
// sweeps the screen store once: it moves the rows up, reading one cell and writing one
// cell a cycle, and then clears the bottom row. After reset the store is cleared one
// cell a cycle, during which no request is accepted; register writes are taken
// throughout. Up to three requests are buffered ahead of the engine, and a finished
// result waits in its own register.
module text_console_writer (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tcw_pkg::PADDR_W-1:0] paddr,
    input  logic [tcw_pkg::PDATA_W-1:0] pwdata,
    output logic [tcw_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  tcw_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output tcw_pkg::out_item_t          m_data
);

    logic [tcw_pkg::ATTR_W-1:0] attr_reg;
    logic [tcw_pkg::TAB_W-1:0]  tab_reg;
    logic                       reg_sel;
    logic                       clearing;
    logic                       f_valid;
    logic                       f_ready;
    tcw_pkg::cmd_t              f_data;
    logic                       q_valid;
    logic                       q_ready;
    tcw_pkg::cmd_t              q_data;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tcw_pkg::ATTR_RESET;
            tab_reg  <= tcw_pkg::TAB_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                tcw_pkg::REG_ATTR: attr_reg <= pwdata[tcw_pkg::ATTR_W-1:0];
                tcw_pkg::REG_TAB:  tab_reg  <= pwdata[tcw_pkg::TAB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            tcw_pkg::REG_ATTR: prdata = tcw_pkg::PDATA_W'(attr_reg);
            tcw_pkg::REG_TAB:  prdata = tcw_pkg::PDATA_W'(tab_reg);
            default:           prdata = '0;
        endcase
    end

    tcw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .clearing  (clearing),
        .cmd_valid (f_valid),
        .cmd_ready (f_ready),
        .cmd_data  (f_data)
    );

    tcw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    tcw_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_valid      (q_valid),
        .cmd_ready      (q_ready),
        .cmd_data       (q_data),
        .text_attribute (attr_reg),
        .tab_advance    (tab_reg),
        .clearing       (clearing),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data)
    );

endmodule

[tb/tb_text_console_writer.sv]
// self-checking testbench of the text console writer: scripted and random requests
module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int STALL_LIMIT = 25000;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        in_item_t  req;
        int        count;
        bit        typed;
        out_item_t res;
    } script_row_t;

    logic                aclk;
    logic                aresetn = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_item_t            s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    out_item_t           m_data;

    logic [15:0]         screen_model [CELL_COUNT];
    int unsigned         cursor_pos   = CURSOR_RESET;
    logic [ATTR_W-1:0]   attr_setting = ATTR_RESET;
    logic [TAB_W-1:0]    tab_setting  = TAB_RESET;

    out_item_t           pending_results [$];
    int                  fault_count  = 0;
    int                  idle_cycles  = 0;
    bit                  sender_burst = 1'b0;
    bit                  sink_burst   = 1'b0;
    bit                  hold_results = 1'b0;

    // scripted requests, reset settings: attribute 07, tab 4, cursor 107
    script_row_t script_rows [22] = '{
        '{'{OP_READ,  8'h00,      11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd107,  1'b0}},
        '{'{OP_READ,  8'h00,      11'd1999}, 1,  1'b1, '{8'h00, 8'h00, 11'd107,  1'b0}},
        '{'{OP_READ,  8'hFF,      11'd2047}, 1,  1'b1, '{8'h00, 8'h00, 11'd107,  1'b0}},
        '{'{OP_PRINT, 8'h41,      11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd108,  1'b0}},
        '{'{OP_READ,  8'h00,      11'd107},  1,  1'b1, '{8'h41, 8'h07, 11'd108,  1'b0}},
        '{'{OP_PRINT, 8'hFF,      11'd2047}, 1,  1'b1, '{8'h00, 8'h00, 11'd109,  1'b0}},
        '{'{OP_READ,  8'h00,      11'd108},  1,  1'b1, '{8'hFF, 8'h07, 11'd109,  1'b0}},
        '{'{OP_PRINT, CH_NUL,     11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd109,  1'b0}},
        '{'{OP_PRINT, CH_TAB,     11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd113,  1'b0}},
        '{'{OP_PRINT, CH_RETURN,  11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd114,  1'b0}},
        '{'{OP_PRINT, CH_NEWLINE, 11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd160,  1'b0}},
        '{'{OP_PRINT, 8'h01,      11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd161,  1'b0}},
        '{'{OP_READ,  8'h00,      11'd160},  1,  1'b1, '{8'h01, 8'h07, 11'd161,  1'b0}},
        '{'{OP_READ,  8'h00,      11'd2000}, 1,  1'b1, '{8'h00, 8'h00, 11'd161,  1'b0}},
        '{'{OP_READ,  8'h00,      11'd113},  1,  1'b1, '{8'h00, 8'h00, 11'd161,  1'b0}},
        '{'{OP_PRINT, CH_NEWLINE, 11'd0},    23, 1'b0, '{8'h00, 8'h00, 11'd0,    1'b0}},
        '{'{OP_PRINT, 8'h42,      11'd0},    1,  1'b1, '{8'h00, 8'h00, 11'd1921, 1'b1}},
        '{'{OP_READ,  8'h00,      11'd1920}, 1,  1'b1, '{8'h42, 8'h07, 11'd1921, 1'b0}},
        '{'{OP_READ,  8'h00,      11'd27},   1,  1'b1, '{8'h41, 8'h07, 11'd1921, 1'b0}},
        '{'{OP_READ,  8'h00,      11'd28},   1,  1'b1, '{8'hFF, 8'h07, 11'd1921, 1'b0}},
        '{'{OP_READ,  8'h00,      11'd80},   1,  1'b1, '{8'h01, 8'h07, 11'd1921, 1'b0}},
        '{'{OP_READ,  8'h00,      11'd1919}, 1,  1'b1, '{8'h00, 8'h00, 11'd1921, 1'b0}}
    };

    text_console_writer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic out_item_t console_predict(input in_item_t req);
        out_item_t res;
        res = '0;
        if (req.opcode == OP_READ) begin
            if (req.cell_index < CELL_COUNT) begin
                res.cell_char = screen_model[req.cell_index][7:0];
                res.cell_attr = screen_model[req.cell_index][15:8];
            end
        end else begin
            if (cursor_pos >= CELL_COUNT) begin
                for (int i = 0; i < MOVE_COUNT; i++)
                    screen_model[i] = screen_model[i + COLUMNS];
                for (int i = MOVE_COUNT; i < CELL_COUNT; i++)
                    screen_model[i] = '0;
                cursor_pos -= COLUMNS;
                if (cursor_pos >= CELL_COUNT)
                    cursor_pos = MOVE_COUNT;
                res.scrolled = 1'b1;
            end
            case (req.character)
                CH_NEWLINE: cursor_pos += COLUMNS - (cursor_pos % COLUMNS);
                CH_TAB:     cursor_pos += tab_setting;
                CH_RETURN:  cursor_pos += 1;
                CH_NUL:     ;
                default: begin
                    if (cursor_pos < CELL_COUNT)
                        screen_model[cursor_pos] = {attr_setting, req.character};
                    cursor_pos += 1;
                end
            endcase
        end
        res.cursor_out = cursor_pos[OUTCUR_W-1:0];
        return res;
    endfunction

    function automatic in_item_t random_request(input bit newline_heavy);
        in_item_t    req;
        int unsigned pick;
        int unsigned back;
        req.opcode     = OP_PRINT;
        req.character  = 8'($urandom_range(0, 255));
        req.cell_index = 11'($urandom_range(0, 2047));
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            req.opcode = OP_READ;
            if (pick < 15) begin
                // near the cursor, where recent prints landed
                back = $urandom_range(1, 40);
                req.cell_index = (cursor_pos > back) ? 11'(cursor_pos - back) : 11'd0;
            end else if (pick < 30) begin
                req.cell_index = 11'($urandom_range(0, CELL_COUNT - 1));
            end else begin
                req.cell_index = 11'($urandom_range(CELL_COUNT, 2047));
            end
        end else if (pick < (newline_heavy ? 45 : 75)) begin
            req.opcode = OP_PRINT;
        end else if (pick < 85) begin
            req.character = CH_NEWLINE;
        end else if (pick < 92) begin
            req.character = CH_TAB;
        end else if (pick < 96) begin
            req.character = CH_RETURN;
        end else begin
            req.character = CH_NUL;
        end
        return req;
    endfunction

    task automatic offer_request(input in_item_t req, input bit typed, input out_item_t typed_res);
        int        gap;
        out_item_t predicted;
        if ($urandom_range(0, 23) == 0)
            sender_burst = !sender_burst;
        gap = sender_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        predicted = console_predict(req);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic write_register(input logic reg_index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (reg_index == REG_ATTR)
            attr_setting = value[ATTR_W-1:0];
        else
            tab_setting = value[TAB_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reconfigure(input logic [PDATA_W-1:0] attr_word,
                               input logic [PDATA_W-1:0] tab_word);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (8) @(posedge aclk);
        write_register(REG_ATTR, attr_word);
        write_register(REG_TAB, tab_word);
    endtask

    // newlines down to the bottom row, fill it, tab past the last cell, then print a character
    task automatic walk_to_last_cell();
        in_item_t req;
        req = '{OP_PRINT, CH_NEWLINE, 11'd0};
        while (cursor_pos / COLUMNS < ROWS - 1)
            offer_request(req, 1'b0, '0);
        req.character = 8'h2A;
        while (cursor_pos < CELL_COUNT - 1)
            offer_request(req, 1'b0, '0);
        req.character = CH_TAB;
        offer_request(req, 1'b0, '0);
        req.character = 8'h2B;
        offer_request(req, 1'b0, '0);
    endtask

    initial begin : stimulus
        foreach (screen_model[i])
            screen_model[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (script_rows[r])
            repeat (script_rows[r].count)
                offer_request(script_rows[r].req, script_rows[r].typed, script_rows[r].res);
        reconfigure(32'h0000_0000, 32'h0000_0000);
        repeat (150) offer_request(random_request(1'b0), 1'b0, '0);
        reconfigure(32'h0000_00FF, 32'h0000_000F);
        // results held back while requests keep coming
        hold_results = 1'b1;
        sender_burst = 1'b1;
        repeat (16) offer_request(random_request(1'b0), 1'b0, '0);
        walk_to_last_cell();
        repeat (100) offer_request(random_request(1'b0), 1'b0, '0);
        reconfigure($urandom(), $urandom());
        repeat (150) offer_request(random_request(1'b1), 1'b0, '0);
        reconfigure($urandom(), $urandom());
        repeat (180) offer_request(random_request(1'b0), 1'b0, '0);
        reconfigure(32'hFFFF_FF00, 32'hFFFF_FFF0);
        repeat (150) offer_request(random_request(1'b0), 1'b0, '0);
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (40) @(posedge aclk);
        if (fault_count == 0)
            $display("tb_text_console_writer OK");
        else
            $display("tb_text_console_writer NOT OK");
        $finish;
    end

    initial begin : result_sink
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_results) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_results = 1'b0;
            end
            if ($urandom_range(0, 23) == 0)
                sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request pending: %p", m_data);
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.cell_char !== want.cell_char) begin
                    $error("cell_char: expected %0h, got %0h", want.cell_char, m_data.cell_char);
                    fault_count++;
                end
                if (m_data.cell_attr !== want.cell_attr) begin
                    $error("cell_attr: expected %0h, got %0h", want.cell_attr, m_data.cell_attr);
                    fault_count++;
                end
                if (m_data.cursor_out !== want.cursor_out) begin
                    $error("cursor_out: expected %0d, got %0d",
                           want.cursor_out, m_data.cursor_out);
                    fault_count++;
                end
                if (m_data.scrolled !== want.scrolled) begin
                    $error("scrolled: expected %0b, got %0b", want.scrolled, m_data.scrolled);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("tb_text_console_writer NOT OK");
            $finish;
        end
    end

endmodule

[sim.f]
rtl/tcw_pkg.sv
rtl/tcw_front.sv
rtl/tcw_queue.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
tb/tb_text_console_writer.sv
